// ===== src/hci_pkg.sv =====
// Package for the RGB to hue / chroma / intensity converter.
// Shared widths, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package hci_pkg;

    // Default channel and hue widths
    localparam int HCI_CHANNEL_BITS = 8;
    localparam int HCI_HUE_BITS     = 16;

    // Fraction bits on chroma and intensity
    localparam int HCI_FRAC_BITS = 4;

    // CORDIC cell count and vector scaling (Q30)
    localparam int HCI_CORDIC_STEPS = 28;
    localparam int HCI_Q            = 30;

    // sqrt(3) in Q30
    localparam logic [30:0] HCI_SQRT3_Q30 = 31'd1859775393;

    // Half a turn in the 32-bit angle accumulator
    localparam logic [31:0] HCI_HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in units of 2pi/2^32
    localparam logic [31:0] HCI_ATAN_TURNS [HCI_CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

endpackage

// ===== src/hci_pixel_if.sv =====
// Pixel input channel: valid/ready handshake with three color channels.
// Depends on hci_pkg for the default channel width.
interface hci_pixel_if
    import hci_pkg::*;
#(
    parameter int CHANNEL_BITS = HCI_CHANNEL_BITS
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== src/hci_result_if.sv =====
// Result channel: valid/ready handshake with hue, hue flag, chroma and intensity.
// Depends on hci_pkg for default widths and fraction bits.
interface hci_result_if
    import hci_pkg::*;
#(
    parameter int CHANNEL_BITS = HCI_CHANNEL_BITS,
    parameter int HUE_BITS     = HCI_HUE_BITS
);
    logic                                  valid;
    logic                                  ready;
    logic [HUE_BITS-1:0]                   hue_angle;
    logic                                  hue_valid;
    logic [CHANNEL_BITS+HCI_FRAC_BITS-1:0] chroma;
    logic [CHANNEL_BITS+HCI_FRAC_BITS-1:0] intensity;

    modport source (output valid, output hue_angle, output hue_valid, output chroma,
                    output intensity, input ready);
    modport sink   (input valid, input hue_angle, input hue_valid, input chroma,
                    input intensity, output ready);
endinterface

// ===== src/hci_front.sv =====
// Front end: two register stages that form the CORDIC start vector, the
// chroma radicand and the intensity numerator. Depends on hci_pkg.
module hci_front
    import hci_pkg::*;
#(
    parameter int CHANNEL_BITS = HCI_CHANNEL_BITS
)(
    input  logic                                        clk,
    input  logic                                        en,
    input  logic [CHANNEL_BITS-1:0]                     red,
    input  logic [CHANNEL_BITS-1:0]                     green,
    input  logic [CHANNEL_BITS-1:0]                     blue,
    output logic signed [CHANNEL_BITS+HCI_Q+2:0]        x_out,
    output logic signed [CHANNEL_BITS+HCI_Q+2:0]        y_out,
    output logic [31:0]                                 z_out,
    output logic [2*(CHANNEL_BITS+HCI_FRAC_BITS)-1:0]   v_out,
    output logic [CHANNEL_BITS+HCI_FRAC_BITS+1:0]       n_out,
    output logic                                        gray_out
);
    localparam int CB = CHANNEL_BITS;
    localparam int XW = CB + HCI_Q + 3;
    localparam int VW = 2 * (CB + HCI_FRAC_BITS);
    localparam int NW = CB + HCI_FRAC_BITS + 2;
    localparam int SH = 2 * HCI_FRAC_BITS - 1;

    // Stage 0 combinational terms
    logic signed [CB+2:0] d_wide;
    logic [CB+2:0]        d_mag;
    logic signed [CB:0]   drg;
    logic signed [CB:0]   dgb;
    logic signed [CB:0]   dbr;
    logic [CB+1:0]        sum3;

    // Stage 0 registers
    logic [CB:0]          d_abs_reg;
    logic                 flip_reg;
    logic signed [CB:0]   dgb_reg;
    logic signed [CB:0]   drg_reg;
    logic signed [CB:0]   dbr_reg;
    logic [NW-1:0]        n_reg;
    logic                 gray_reg;

    // Stage 1 combinational terms
    logic signed [2*CB+1:0] sq_rg;
    logic signed [2*CB+1:0] sq_gb;
    logic signed [2*CB+1:0] sq_br;
    logic signed [2*CB+1:0] ssum;
    logic signed [XW-1:0]   y_prod;

    // Stage 1 registers
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic [31:0]          z_reg;
    logic [VW-1:0]        v_reg;
    logic [NW-1:0]        n1_reg;
    logic                 gray1_reg;

    // Channel differences, 2r-g-b and its magnitude, channel sum
    always_comb
    begin
        d_wide = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
                 - $signed({3'b000, blue});
        d_mag  = d_wide[CB+2] ? (~d_wide + 1'b1) : d_wide;
        drg    = $signed({1'b0, red})   - $signed({1'b0, green});
        dgb    = $signed({1'b0, green}) - $signed({1'b0, blue});
        dbr    = $signed({1'b0, blue})  - $signed({1'b0, red});
        sum3   = {2'b00, red} + {2'b00, green} + {2'b00, blue};
    end

    // Stage 0: left half-plane vectors are mirrored before scaling
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_abs_reg <= d_mag[CB:0];
            flip_reg  <= d_wide[CB+2];
            dgb_reg   <= d_wide[CB+2] ? -dgb : dgb;
            drg_reg   <= drg;
            dbr_reg   <= dbr;
            n_reg     <= {sum3, {(HCI_FRAC_BITS-1){1'b0}}, 1'b1};
            gray_reg  <= (red == green) && (green == blue);
        end
    end

    // Sum of squared differences and sqrt(3) scaling of g-b
    always_comb
    begin
        sq_rg  = drg_reg * drg_reg;
        sq_gb  = dgb_reg * dgb_reg;
        sq_br  = dbr_reg * dbr_reg;
        ssum   = sq_rg + sq_gb + sq_br;
        y_prod = dgb_reg * $signed({1'b0, HCI_SQRT3_Q30});
    end

    // Stage 1: CORDIC start vector, radicand 128*ssum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= {2'b00, d_abs_reg, {HCI_Q{1'b0}}};
            y_reg     <= y_prod;
            z_reg     <= flip_reg ? HCI_HALF_TURN : 32'd0;
            v_reg     <= {ssum[2*CB:0], {SH{1'b0}}};
            n1_reg    <= n_reg;
            gray1_reg <= gray_reg;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign v_out    = v_reg;
    assign n_out    = n1_reg;
    assign gray_out = gray1_reg;
endmodule

// ===== src/hci_cordic_cell.sv =====
// One vectoring CORDIC cell: a fixed-shift rotation toward the x axis with
// its angle update, registered. Depends on hci_pkg for the arctangent table.
module hci_cordic_cell
    import hci_pkg::*;
#(
    parameter int XW   = HCI_CHANNEL_BITS + HCI_Q + 3,
    parameter int STEP = 0
)(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic [31:0]          z_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic [31:0]          z_out
);
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic [31:0]          z_next;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic [31:0]          z_reg;

    // Rotate clockwise while y is positive, otherwise counterclockwise
    always_comb
    begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        if (!y_in[XW-1] && (y_in != '0))
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + HCI_ATAN_TURNS[STEP];
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - HCI_ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

// ===== src/hci_sqrt_cell.sv =====
// One digit cell of the bitwise integer square root, registered. Cells past
// the last root digit only carry the partial result along. Uses hci_pkg.
module hci_sqrt_cell
    import hci_pkg::*;
#(
    parameter int VW     = 2 * (HCI_CHANNEL_BITS + HCI_FRAC_BITS),
    parameter int STEP   = 0,
    parameter bit ACTIVE = 1'b1
)(
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] rem_in,
    input  logic [VW-1:0] root_in,
    output logic [VW-1:0] rem_out,
    output logic [VW-1:0] root_out
);
    logic [VW-1:0] rem_next;
    logic [VW-1:0] root_next;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] root_reg;

    generate
        if (ACTIVE)
        begin : g_digit
            localparam logic [VW-1:0] DIGIT_BIT = {{(VW-1){1'b0}}, 1'b1} << (VW - 2 - 2*STEP);
            logic [VW-1:0] trial;

            // Subtract the trial value when it fits and set this root digit
            always_comb
            begin
                trial = root_in + DIGIT_BIT;
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = (root_in >> 1) + DIGIT_BIT;
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in >> 1;
                end
            end
        end
        else
        begin : g_carry
            always_comb
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// ===== src/rgb_to_hue_chroma_intensity.sv =====
// RGB to hue / chroma / intensity converter, fully pipelined.
// An input transfer reaches the result valid at the output through two front stages,
// a chain of 28 CORDIC cells and the output register.
// Throughput: one pixel per cycle; one skid entry sits behind the output register
// and input stalls only while that entry holds a result. Reset clears valid flags only.
// Depends on hci_pkg, hci_pixel_if, hci_result_if and the hci cell modules.
module rgb_to_hue_chroma_intensity
    import hci_pkg::*;
#(
    parameter int CHANNEL_BITS = HCI_CHANNEL_BITS,
    parameter int HUE_BITS     = HCI_HUE_BITS
)(
    input  logic         clk,
    input  logic         rst_n,
    hci_pixel_if.sink    pixel,
    hci_result_if.source result
);
    localparam int RB          = CHANNEL_BITS + HCI_FRAC_BITS;
    localparam int VW          = 2 * RB;
    localparam int XW          = CHANNEL_BITS + HCI_Q + 3;
    localparam int NW          = RB + 2;
    localparam int KW          = NW + 1;
    localparam int N           = HCI_CORDIC_STEPS;
    localparam int PIPE_STAGES = N + 2;
    localparam int SQRT_STEPS  = RB;

    // ceil(2^KW/3): exact floor division by 3 for numerators below 2^NW
    localparam longint unsigned RECIP3_FULL = ((longint'(1) << KW) + 2) / 3;
    localparam logic [KW-1:0]   RECIP3      = RECIP3_FULL[KW-1:0];
    localparam logic [31:0]     HUE_HALF    = 32'd1 << (31 - HUE_BITS);

    // Pipeline flow control
    logic                   adv;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;

    // Stage data along the cell chain
    logic signed [XW-1:0] x_pipe    [0:N];
    logic signed [XW-1:0] y_pipe    [0:N];
    logic [31:0]          z_pipe    [0:N];
    logic [VW-1:0]        rem_pipe  [0:N];
    logic [VW-1:0]        root_pipe [0:N];
    logic                 gray_pipe [1:N];
    logic [RB-1:0]        inten_pipe[1:N];
    logic [NW-1:0]        n_front;
    logic                 gray_front;

    // Result rounding
    logic [31:0]         hue_sum;
    logic [VW-1:0]       chroma_sum;
    logic [HUE_BITS-1:0] hue_next;
    logic                hue_valid_next;
    logic [RB-1:0]       chroma_next;
    logic [RB-1:0]       inten_next;

    // Output register and skid entry
    logic                out_free;
    logic                leaving;
    logic                out_load;
    logic                out_from_skid;
    logic                skid_load;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic                skid_vld_reg;
    logic                skid_vld_next;
    logic [HUE_BITS-1:0] hue_reg;
    logic                hue_valid_reg;
    logic [RB-1:0]       chroma_reg;
    logic [RB-1:0]       inten_reg;
    logic [HUE_BITS-1:0] skid_hue_reg;
    logic                skid_hue_valid_reg;
    logic [RB-1:0]       skid_chroma_reg;
    logic [RB-1:0]       skid_inten_reg;

    // The whole chain moves unless the skid entry is occupied
    assign adv         = !skid_vld_reg;
    assign pixel.ready = adv;
    assign vld_next    = {vld_reg[PIPE_STAGES-2:0], pixel.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Front stages
    hci_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk      (clk),
        .en       (adv),
        .red      (pixel.red),
        .green    (pixel.green),
        .blue     (pixel.blue),
        .x_out    (x_pipe[0]),
        .y_out    (y_pipe[0]),
        .z_out    (z_pipe[0]),
        .v_out    (rem_pipe[0]),
        .n_out    (n_front),
        .gray_out (gray_front)
    );

    assign root_pipe[0] = '0;

    // Cell chain: CORDIC cell, square root digit cell and side-band carry
    generate
        for (genvar i = 0; i < N; i++)
        begin : g_cell
            hci_cordic_cell #(
                .XW   (XW),
                .STEP (i)
            ) u_cordic (
                .clk   (clk),
                .en    (adv),
                .x_in  (x_pipe[i]),
                .y_in  (y_pipe[i]),
                .z_in  (z_pipe[i]),
                .x_out (x_pipe[i+1]),
                .y_out (y_pipe[i+1]),
                .z_out (z_pipe[i+1])
            );

            hci_sqrt_cell #(
                .VW     (VW),
                .STEP   (i),
                .ACTIVE (i < SQRT_STEPS)
            ) u_sqrt (
                .clk      (clk),
                .en       (adv),
                .rem_in   (rem_pipe[i]),
                .root_in  (root_pipe[i]),
                .rem_out  (rem_pipe[i+1]),
                .root_out (root_pipe[i+1])
            );

            if (i == 0)
            begin : g_first
                logic [NW+KW-1:0] inten_prod;

                // Intensity (16S+1)/3 by reciprocal multiply
                assign inten_prod = n_front * RECIP3;

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        gray_pipe[1]  <= gray_front;
                        inten_pipe[1] <= inten_prod[KW +: RB];
                    end
                end
            end
            else
            begin : g_rest
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        gray_pipe[i+1]  <= gray_pipe[i];
                        inten_pipe[i+1] <= inten_pipe[i];
                    end
                end
            end
        end
    endgenerate

    // Final rounding of hue and chroma
    always_comb
    begin
        hue_sum        = z_pipe[N] + HUE_HALF;
        hue_next       = gray_pipe[N] ? '0 : hue_sum[31 -: HUE_BITS];
        hue_valid_next = !gray_pipe[N];
        chroma_sum     = root_pipe[N] + {{(VW-1){1'b0}}, (rem_pipe[N] > root_pipe[N])};
        chroma_next    = chroma_sum[RB-1:0];
        inten_next     = inten_pipe[N];
    end

    // Output register / skid control
    always_comb
    begin
        out_free      = !out_vld_reg || result.ready;
        leaving       = adv && vld_reg[PIPE_STAGES-1];
        out_load      = 1'b0;
        out_from_skid = 1'b0;
        skid_load     = 1'b0;
        if (out_free)
        begin
            out_load      = 1'b1;
            out_from_skid = skid_vld_reg;
            out_vld_next  = skid_vld_reg || leaving;
            skid_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next  = 1'b1;
            skid_load     = leaving;
            skid_vld_next = skid_vld_reg || leaving;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (out_from_skid)
            begin
                hue_reg       <= skid_hue_reg;
                hue_valid_reg <= skid_hue_valid_reg;
                chroma_reg    <= skid_chroma_reg;
                inten_reg     <= skid_inten_reg;
            end
            else
            begin
                hue_reg       <= hue_next;
                hue_valid_reg <= hue_valid_next;
                chroma_reg    <= chroma_next;
                inten_reg     <= inten_next;
            end
        end
        if (skid_load)
        begin
            skid_hue_reg       <= hue_next;
            skid_hue_valid_reg <= hue_valid_next;
            skid_chroma_reg    <= chroma_next;
            skid_inten_reg     <= inten_next;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.hue_angle = hue_reg;
    assign result.hue_valid = hue_valid_reg;
    assign result.chroma    = chroma_reg;
    assign result.intensity = inten_reg;
endmodule

// ===== bench/tb_rgb_to_hue_chroma_intensity.sv =====
// Testbench for rgb_to_hue_chroma_intensity: runs directed and random pixel streams
// and checks every result against a behavioral integer CORDIC / sqrt converter.
// Depends on hci_pkg, hci_pixel_if, hci_result_if and the converter RTL.
module tb_rgb_to_hue_chroma_intensity;
    timeunit 1ns;
    timeprecision 1ps;

    import hci_pkg::*;

    localparam int CH_BITS  = HCI_CHANNEL_BITS;
    localparam int HUE_W    = HCI_HUE_BITS;
    localparam int OUT_W    = HCI_CHANNEL_BITS + HCI_FRAC_BITS;
    localparam int CH_MAX   = (1 << CH_BITS) - 1;
    localparam int N_CELLS  = 28;
    localparam int IDLE_PCT = 21;
    localparam int SHOW_MAX = 10;
    // wait after draining, with margin beyond the pipeline length
    localparam int DRAIN_CYCLES = 40;

    localparam logic [31:0]  TURN_HALF  = 32'h8000_0000;
    localparam longint       ONE_Q30    = 64'sd1073741824;
    localparam longint       ROOT3_Q30  = 64'sd1859775393;

    // atan(2^-i) as a fraction of a turn, 2^32 per turn
    localparam logic [31:0] ARCTAN_TURNS [N_CELLS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    // One pixel with the color it is expected to convert to
    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
        logic [HUE_W-1:0]   hue_angle;
        logic               hue_valid;
        logic [OUT_W-1:0]   chroma;
        logic [OUT_W-1:0]   intensity;
    } hci_color_t;

    logic clk;
    logic rst_n;

    hci_pixel_if  pixel_bus ();
    hci_result_if result_bus ();

    hci_color_t expected_colors [$];
    bit         steady_flow;
    int         mismatch_count;
    int         pixels_sent;
    int         gray_sent;
    int         results_checked;

    rgb_to_hue_chroma_intensity i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus),
        .result (result_bus)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Angle of (x, y) in turns, 2^32 per turn, by vectoring CORDIC
    function automatic logic [31:0] vector_turns(longint x, longint y);
        logic [31:0] z;
        longint      xs;
        longint      ys;
        z = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = TURN_HALF;
        end
        for (int i = 0; i < N_CELLS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_TURNS[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_TURNS[i];
            end
        end
        return z;
    endfunction

    // sqrt rounded to nearest
    function automatic longint nearest_sqrt(longint v);
        longint root;
        longint trial;
        longint rem;
        root = 0;
        for (int k = 14; k >= 0; k--)
        begin
            trial = root | (64'sd1 << k);
            if (trial * trial <= v)
                root = trial;
        end
        rem = v - root * root;
        if (rem > root)
            root++;
        return root;
    endfunction

    // Expected hue / chroma / intensity for one pixel
    function automatic hci_color_t convert_pixel(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
                                                 logic [CH_BITS-1:0] b);
        hci_color_t  c;
        longint      ri;
        longint      gi;
        longint      bi;
        longint      sq_sum;
        logic [31:0] z;
        logic [32:0] z_round;
        ri = r;
        gi = g;
        bi = b;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        sq_sum = (ri - gi) * (ri - gi) + (gi - bi) * (gi - bi) + (bi - ri) * (bi - ri);
        // 16*C = sqrt(128 * sum of squared differences)
        c.chroma    = OUT_W'(nearest_sqrt(sq_sum * 128));
        c.intensity = OUT_W'(((ri + gi + bi) * 32 + 3) / 6);
        c.hue_angle = '0;
        c.hue_valid = 1'b0;
        if (!(ri == gi && gi == bi))
        begin
            z = vector_turns((2 * ri - gi - bi) * ONE_Q30, (gi - bi) * ROOT3_Q30);
            z_round = {1'b0, z} + (33'd1 << (31 - HUE_W));
            // a full turn falls off the top and wraps to 0
            c.hue_angle = z_round[31 -: HUE_W];
            c.hue_valid = 1'b1;
        end
        return c;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX)
            $display("tb: ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Compare one result transfer against the oldest expectation
    task automatic check_result();
        hci_color_t       want;
        logic [HUE_W-1:0] hue_diff;
        logic             hue_ok;
        if (expected_colors.size() == 0)
        begin
            flag_mismatch($sformatf("result with nothing pending: hue %0d/%0d C %0d I %0d",
                result_bus.hue_angle, result_bus.hue_valid, result_bus.chroma,
                result_bus.intensity));
            return;
        end
        want = expected_colors.pop_front();
        results_checked++;
        hue_diff = result_bus.hue_angle - want.hue_angle;
        // hue within one LSB around the circle; exactly 0 for gray
        if (want.hue_valid)
            hue_ok = (hue_diff === '0) || (hue_diff === HUE_W'(1)) || (hue_diff === '1);
        else
            hue_ok = (result_bus.hue_angle === '0);
        if (!hue_ok || result_bus.hue_valid !== want.hue_valid ||
            result_bus.chroma !== want.chroma || result_bus.intensity !== want.intensity)
            flag_mismatch($sformatf(
                "rgb (%0d,%0d,%0d) exp hue %0d/%0d C %0d I %0d, got hue %0d/%0d C %0d I %0d",
                want.red, want.green, want.blue, want.hue_angle, want.hue_valid,
                want.chroma, want.intensity, result_bus.hue_angle, result_bus.hue_valid,
                result_bus.chroma, result_bus.intensity));
    endtask

    // Result side: check each transfer, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            check_result();
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // Send one pixel; returns at the edge of its transfer with valid still high
    task automatic send_pixel(int r, int g, int b);
        if (!steady_flow)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                pixel_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pixel_bus.valid <= 1'b1;
        pixel_bus.red   <= CH_BITS'(r);
        pixel_bus.green <= CH_BITS'(g);
        pixel_bus.blue  <= CH_BITS'(b);
        do
            @(posedge clk);
        while (pixel_bus.ready !== 1'b1);
        expected_colors.push_back(convert_pixel(CH_BITS'(r), CH_BITS'(g), CH_BITS'(b)));
        pixels_sent++;
        if (r == g && g == b)
            gray_sent++;
    endtask

    function automatic int clamp_channel(int v);
        if (v < 0)
            return 0;
        if (v > CH_MAX)
            return CH_MAX;
        return v;
    endfunction

    // Black, white, gray, primaries, secondaries, hue near the full turn and near
    // half a turn, smallest nonzero differences and alternating bit patterns
    task automatic test_directed_corners();
        send_pixel(0, 0, 0);
        send_pixel(CH_MAX, CH_MAX, CH_MAX);
        send_pixel(128, 128, 128);
        send_pixel(1, 1, 1);
        send_pixel(CH_MAX, 0, 0);
        send_pixel(0, CH_MAX, 0);
        send_pixel(0, 0, CH_MAX);
        send_pixel(CH_MAX, CH_MAX, 0);
        send_pixel(0, CH_MAX, CH_MAX);
        send_pixel(CH_MAX, 0, CH_MAX);
        send_pixel(CH_MAX, 0, 1);
        send_pixel(CH_MAX, 1, 0);
        send_pixel(200, 10, 10);
        send_pixel(10, 200, 200);
        send_pixel(1, 0, 0);
        send_pixel(0, 1, 0);
        send_pixel(0, 0, 1);
        send_pixel(254, CH_MAX, CH_MAX);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h0F, 8'hF0, 8'h3C);
        send_pixel(CH_MAX, 128, 0);
    endtask

    // Uniform random pixels with idling on both sides
    task automatic test_random_pixels(int count);
        repeat (count)
            send_pixel($urandom_range(CH_MAX), $urandom_range(CH_MAX), $urandom_range(CH_MAX));
    endtask

    // Back-to-back transfers, no idling anywhere
    task automatic test_steady_stream(int count);
        steady_flow = 1'b1;
        repeat (count)
            send_pixel($urandom_range(CH_MAX), $urandom_range(CH_MAX), $urandom_range(CH_MAX));
        steady_flow = 1'b0;
    endtask

    // Gray and almost-gray pixels: small chroma, hue flag edge
    task automatic test_near_gray(int count);
        int base;
        repeat (count)
        begin
            base = $urandom_range(CH_MAX);
            send_pixel(clamp_channel(base + $urandom_range(4) - 2),
                       clamp_channel(base + $urandom_range(4) - 2),
                       clamp_channel(base + $urandom_range(4) - 2));
        end
    endtask

    // Two equal channels: hue on or next to the primary / secondary axes
    task automatic test_hue_axes(int count);
        int pair;
        int same;
        int other;
        repeat (count)
        begin
            pair  = $urandom_range(2);
            same  = $urandom_range(CH_MAX);
            other = $urandom_range(CH_MAX);
            unique case (pair)
                0: send_pixel(other, same, same);
                1: send_pixel(same, other, same);
                default: send_pixel(same, same, other);
            endcase
        end
    endtask

    // Run limit
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        steady_flow      = 1'b0;
        mismatch_count   = 0;
        pixels_sent      = 0;
        gray_sent        = 0;
        results_checked  = 0;
        pixel_bus.valid  <= 1'b0;
        pixel_bus.red    <= '0;
        pixel_bus.green  <= '0;
        pixel_bus.blue   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_pixels(250);
        test_steady_stream(150);
        test_near_gray(100);
        test_hue_axes(100);
        pixel_bus.valid <= 1'b0;

        // drain the pipeline, then watch for stray results
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d pixels converted (%0d gray), %0d results checked, %0d mismatches",
                 pixels_sent, gray_sent, results_checked, mismatch_count);
        $display("tb: covered corners, random, back-to-back, near-gray and equal-channel hues");
        if (mismatch_count == 0 && expected_colors.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
